FILE: rtl/core/tlpm_pkg.sv
// Shared definitions for the trie longest-prefix-match route table.
// Holds default sizes, field codes and the walker state type.
// No dependencies; used by every module in rtl/core.
package tlpm_pkg;

    // Default sizing for the top-level parameters
    localparam int MAX_NODES_DFLT  = 16384;
    localparam int PORT_COUNT_DFLT = 4;
    localparam int KEY_BITS_DFLT   = 32;

    // Fixed field widths
    localparam int HOP_W = 32;

    // Depth of the item queue between front and walker
    localparam int QUEUE_DEPTH = 2;

    // Item kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Walker sequencer states
    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_STEP,
        WALK_FINISH
    } walk_state_t;

endpackage

FILE: rtl/core/tlpm_front.sv
// Front end of the route table: accepts transactions, classifies them and
// queues them for the trie walker. Depends on tlpm_pkg.
// The walk key and walk length are chosen here so the walker sees one form.
module tlpm_front #(
    parameter int KEY_BITS   = tlpm_pkg::KEY_BITS_DFLT,
    parameter int PORT_COUNT = tlpm_pkg::PORT_COUNT_DFLT,
    localparam int LEN_W     = $clog2(KEY_BITS + 1),
    localparam int PORT_W    = $clog2(PORT_COUNT)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Input transaction side
    input  logic                     push,
    output logic                     full,
    input  logic                     kind,
    input  logic [KEY_BITS-1:0]      prefix_value,
    input  logic [LEN_W-1:0]         prefix_length,
    input  logic [tlpm_pkg::HOP_W-1:0] route_next_hop,
    input  logic [PORT_W-1:0]        route_port,
    input  logic [KEY_BITS-1:0]      dest_address,
    // Queued item toward the walker
    output logic                     item_valid,
    input  logic                     item_take,
    output logic                     item_kind,
    output logic [KEY_BITS-1:0]      item_key,
    output logic [LEN_W-1:0]         item_len,
    output logic [tlpm_pkg::HOP_W-1:0] item_hop,
    output logic [PORT_W-1:0]        item_port
);

    localparam int PTR_W = (tlpm_pkg::QUEUE_DEPTH > 1) ? $clog2(tlpm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tlpm_pkg::QUEUE_DEPTH + 1);

    logic                       kind_q [tlpm_pkg::QUEUE_DEPTH];
    logic [KEY_BITS-1:0]        key_q  [tlpm_pkg::QUEUE_DEPTH];
    logic [LEN_W-1:0]           len_q  [tlpm_pkg::QUEUE_DEPTH];
    logic [tlpm_pkg::HOP_W-1:0] hop_q  [tlpm_pkg::QUEUE_DEPTH];
    logic [PORT_W-1:0]          port_q [tlpm_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                do_push;
    logic                do_pop;
    logic [KEY_BITS-1:0] key_in;
    logic [LEN_W-1:0]    len_in;

    assign full       = (count_reg == CNT_W'(tlpm_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // Classify: pick the walk key, saturate insert length, lookups walk all bits
    always_comb
    begin
        if (kind == tlpm_pkg::KIND_LOOKUP)
        begin
            key_in = dest_address;
            len_in = LEN_W'(KEY_BITS);
        end
        else
        begin
            key_in = prefix_value;
            if (prefix_length > LEN_W'(KEY_BITS))
                len_in = LEN_W'(KEY_BITS);
            else
                len_in = prefix_length;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_W'(tlpm_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_W'(tlpm_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_q[wr_ptr_reg] <= kind;
            key_q[wr_ptr_reg]  <= key_in;
            len_q[wr_ptr_reg]  <= len_in;
            hop_q[wr_ptr_reg]  <= route_next_hop;
            port_q[wr_ptr_reg] <= route_port;
        end
    end

    assign item_kind = kind_q[rd_ptr_reg];
    assign item_key  = key_q[rd_ptr_reg];
    assign item_len  = len_q[rd_ptr_reg];
    assign item_hop  = hop_q[rd_ptr_reg];
    assign item_port = port_q[rd_ptr_reg];

endmodule

FILE: rtl/core/tlpm_walker.sv
// Back end of the route table: node pool memory, root node registers and the
// one-level-per-cycle trie walk for inserts and lookups, plus the result register.
// Depends on tlpm_pkg.
module tlpm_walker #(
    parameter int MAX_NODES  = tlpm_pkg::MAX_NODES_DFLT,
    parameter int PORT_COUNT = tlpm_pkg::PORT_COUNT_DFLT,
    parameter int KEY_BITS   = tlpm_pkg::KEY_BITS_DFLT,
    localparam int LEN_W     = $clog2(KEY_BITS + 1),
    localparam int PORT_W    = $clog2(PORT_COUNT)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Item from the front queue
    input  logic                       item_valid,
    output logic                       item_take,
    input  logic                       item_kind,
    input  logic [KEY_BITS-1:0]        item_key,
    input  logic [LEN_W-1:0]           item_len,
    input  logic [tlpm_pkg::HOP_W-1:0] item_hop,
    input  logic [PORT_W-1:0]          item_port,
    // Result side
    output logic                       empty,
    input  logic                       pop,
    output logic                       status,
    output logic                       found,
    output logic [tlpm_pkg::HOP_W-1:0] match_next_hop,
    output logic [PORT_W-1:0]          match_port,
    output logic [LEN_W-1:0]           match_length
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int FREE_W = NODE_W + 1;
    localparam int IDX_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int WORD_W = 1 + 2 * NODE_W + PORT_W + tlpm_pkg::HOP_W;

    // Node pool: {holds, child one, child zero, port, next hop}
    logic [WORD_W-1:0] node_mem [MAX_NODES];
    logic [WORD_W-1:0] rd_data_reg;
    logic [NODE_W-1:0] rd_addr;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    tlpm_pkg::walk_state_t state_reg, state_next;

    logic [NODE_W-1:0]          cur_reg, cur_next;
    logic                       fresh_reg, fresh_next;
    logic [LEN_W-1:0]           depth_reg, depth_next;
    logic                       kind_reg, kind_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [tlpm_pkg::HOP_W-1:0] hop_reg, hop_next;
    logic [PORT_W-1:0]          port_reg, port_next;
    logic [FREE_W-1:0]          next_free_reg, next_free_next;

    logic                       root_holds_reg, root_holds_next;
    logic [NODE_W-1:0]          root_c0_reg, root_c0_next;
    logic [NODE_W-1:0]          root_c1_reg, root_c1_next;
    logic [tlpm_pkg::HOP_W-1:0] root_hop_reg, root_hop_next;
    logic [PORT_W-1:0]          root_port_reg, root_port_next;

    logic                       best_found_reg, best_found_next;
    logic [tlpm_pkg::HOP_W-1:0] best_hop_reg, best_hop_next;
    logic [PORT_W-1:0]          best_port_reg, best_port_next;
    logic [LEN_W-1:0]           best_len_reg, best_len_next;
    logic                       status_reg, status_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_status_reg, out_status_next;
    logic                       out_found_reg, out_found_next;
    logic [tlpm_pkg::HOP_W-1:0] out_hop_reg, out_hop_next;
    logic [PORT_W-1:0]          out_port_reg, out_port_next;
    logic [LEN_W-1:0]           out_len_reg, out_len_next;

    // Current node view
    logic                       cur_root;
    logic                       nd_holds;
    logic [NODE_W-1:0]          nd_c0;
    logic [NODE_W-1:0]          nd_c1;
    logic [tlpm_pkg::HOP_W-1:0] nd_hop;
    logic [PORT_W-1:0]          nd_port;
    logic                       key_bit;
    logic [NODE_W-1:0]          nxt;
    logic                       nxt_in_pool;
    logic                       pool_full;

    // Node write-back fields
    logic                       wr_holds;
    logic [NODE_W-1:0]          wr_c0;
    logic [NODE_W-1:0]          wr_c1;
    logic [tlpm_pkg::HOP_W-1:0] wr_hop;
    logic [PORT_W-1:0]          wr_port;
    logic                       wr_commit;

    assign cur_root = (cur_reg == '0) && !fresh_reg;

    // Select current node: fresh nodes read as cleared, root lives in registers
    always_comb
    begin
        if (fresh_reg)
        begin
            nd_holds = 1'b0;
            nd_c0    = '0;
            nd_c1    = '0;
            nd_hop   = '0;
            nd_port  = '0;
        end
        else if (cur_reg == '0)
        begin
            nd_holds = root_holds_reg;
            nd_c0    = root_c0_reg;
            nd_c1    = root_c1_reg;
            nd_hop   = root_hop_reg;
            nd_port  = root_port_reg;
        end
        else
        begin
            {nd_holds, nd_c1, nd_c0, nd_port, nd_hop} = rd_data_reg;
        end
    end

    assign key_bit     = key_reg[depth_reg[IDX_W-1:0]];
    assign nxt         = key_bit ? nd_c1 : nd_c0;
    assign nxt_in_pool = ({1'b0, nxt} < FREE_W'(MAX_NODES));
    assign pool_full   = (next_free_reg >= FREE_W'(MAX_NODES));
    assign rd_addr     = nxt;
    assign mem_wdata   = {wr_holds, wr_c1, wr_c0, wr_port, wr_hop};

    // Sequencer: next state, walk decisions and node updates
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        depth_next      = depth_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        hop_next        = hop_reg;
        port_next       = port_reg;
        next_free_next  = next_free_reg;
        root_holds_next = root_holds_reg;
        root_c0_next    = root_c0_reg;
        root_c1_next    = root_c1_reg;
        root_hop_next   = root_hop_reg;
        root_port_next  = root_port_reg;
        best_found_next = best_found_reg;
        best_hop_next   = best_hop_reg;
        best_port_next  = best_port_reg;
        best_len_next   = best_len_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_hop_next    = out_hop_reg;
        out_port_next   = out_port_reg;
        out_len_next    = out_len_reg;
        item_take       = 1'b0;
        wr_holds        = nd_holds;
        wr_c0           = nd_c0;
        wr_c1           = nd_c1;
        wr_hop          = nd_hop;
        wr_port         = nd_port;
        wr_commit       = 1'b0;

        case (state_reg)
            tlpm_pkg::WALK_IDLE:
            begin
                // Take the next item and seed the best match from the root route
                if (item_valid)
                begin
                    item_take       = 1'b1;
                    kind_next       = item_kind;
                    key_next        = item_key;
                    len_next        = item_len;
                    hop_next        = item_hop;
                    port_next       = item_port;
                    cur_next        = '0;
                    fresh_next      = 1'b0;
                    depth_next      = '0;
                    best_found_next = (item_kind == tlpm_pkg::KIND_LOOKUP) && root_holds_reg;
                    best_hop_next   = root_hop_reg;
                    best_port_next  = root_port_reg;
                    best_len_next   = '0;
                    status_next     = tlpm_pkg::STATUS_DONE;
                    state_next      = tlpm_pkg::WALK_STEP;
                end
            end

            tlpm_pkg::WALK_STEP:
            begin
                if (kind_reg == tlpm_pkg::KIND_LOOKUP)
                begin
                    // Record a deeper route, then descend or stop
                    if (!cur_root && nd_holds)
                    begin
                        best_found_next = 1'b1;
                        best_hop_next   = nd_hop;
                        best_port_next  = nd_port;
                        best_len_next   = depth_reg;
                    end
                    if ((depth_reg == len_reg) || (nxt == '0) || !nxt_in_pool)
                    begin
                        state_next = tlpm_pkg::WALK_FINISH;
                    end
                    else
                    begin
                        cur_next   = nxt;
                        depth_next = depth_reg + LEN_W'(1);
                    end
                end
                else if (depth_reg == len_reg)
                begin
                    // Store the route at the final node
                    wr_holds   = 1'b1;
                    wr_hop     = hop_reg;
                    wr_port    = port_reg;
                    wr_commit  = 1'b1;
                    state_next = tlpm_pkg::WALK_FINISH;
                end
                else if (!fresh_reg && (nxt != '0))
                begin
                    // Follow an existing child
                    cur_next   = nxt;
                    depth_next = depth_reg + LEN_W'(1);
                end
                else if (pool_full)
                begin
                    // Drop the route; a fresh node is left cleared
                    status_next = tlpm_pkg::STATUS_FULL;
                    wr_commit   = fresh_reg;
                    state_next  = tlpm_pkg::WALK_FINISH;
                end
                else
                begin
                    // Allocate a child and link it from the current node
                    if (key_bit)
                        wr_c1 = next_free_reg[NODE_W-1:0];
                    else
                        wr_c0 = next_free_reg[NODE_W-1:0];
                    wr_commit      = 1'b1;
                    next_free_next = next_free_reg + FREE_W'(1);
                    cur_next       = next_free_reg[NODE_W-1:0];
                    fresh_next     = 1'b1;
                    depth_next     = depth_reg + LEN_W'(1);
                end
            end

            tlpm_pkg::WALK_FINISH:
            begin
                // Load the result once the result register is free
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    if (kind_reg == tlpm_pkg::KIND_LOOKUP)
                    begin
                        out_status_next = tlpm_pkg::STATUS_DONE;
                        out_found_next  = best_found_reg;
                        out_hop_next    = best_found_reg ? best_hop_reg : '0;
                        out_port_next   = best_found_reg ? best_port_reg : '0;
                        out_len_next    = best_found_reg ? best_len_reg : '0;
                    end
                    else
                    begin
                        out_status_next = status_reg;
                        out_found_next  = 1'b0;
                        out_hop_next    = '0;
                        out_port_next   = '0;
                        out_len_next    = '0;
                    end
                    state_next = tlpm_pkg::WALK_IDLE;
                end
            end

            default:
            begin
                state_next = tlpm_pkg::WALK_IDLE;
            end
        endcase

        // Route the node write to root registers or the pool
        mem_we = 1'b0;
        if (wr_commit)
        begin
            if (cur_root)
            begin
                root_holds_next = wr_holds;
                root_c0_next    = wr_c0;
                root_c1_next    = wr_c1;
                root_hop_next   = wr_hop;
                root_port_next  = wr_port;
            end
            else
            begin
                mem_we = 1'b1;
            end
        end
    end

    // Node pool: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[cur_reg] <= mem_wdata;
        rd_data_reg <= node_mem[rd_addr];
    end

    // Control and root registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlpm_pkg::WALK_IDLE;
            next_free_reg  <= FREE_W'(1);
            root_holds_reg <= 1'b0;
            root_c0_reg    <= '0;
            root_c1_reg    <= '0;
            root_hop_reg   <= '0;
            root_port_reg  <= '0;
            out_valid_reg  <= 1'b0;
            fresh_reg      <= 1'b0;
            cur_reg        <= '0;
            depth_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_free_reg  <= next_free_next;
            root_holds_reg <= root_holds_next;
            root_c0_reg    <= root_c0_next;
            root_c1_reg    <= root_c1_next;
            root_hop_reg   <= root_hop_next;
            root_port_reg  <= root_port_next;
            out_valid_reg  <= out_valid_next;
            fresh_reg      <= fresh_next;
            cur_reg        <= cur_next;
            depth_reg      <= depth_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        hop_reg        <= hop_next;
        port_reg       <= port_next;
        best_found_reg <= best_found_next;
        best_hop_reg   <= best_hop_next;
        best_port_reg  <= best_port_next;
        best_len_reg   <= best_len_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_hop_reg    <= out_hop_next;
        out_port_reg   <= out_port_next;
        out_len_reg    <= out_len_next;
    end

    assign empty          = !out_valid_reg;
    assign status         = out_status_reg;
    assign found          = out_found_reg;
    assign match_next_hop = out_hop_reg;
    assign match_port     = out_port_reg;
    assign match_length   = out_len_reg;

endmodule

FILE: rtl/core/trie_longest_prefix_match.sv
// Binary-trie longest-prefix-match route table, one address bit per trie level,
// walked from bit 0. Insert transactions (kind 0) walk prefix_length bits of
// prefix_value (lengths above KEY_BITS saturate), take new nodes from a pool of
// MAX_NODES as needed and store next hop and port at the final node, replacing an
// older route; if the pool runs out, nodes already made stay and status is 1.
// Lookup transactions (kind 1) return the deepest route on dest_address's path,
// the root default route included. Each item yields exactly one result. The walk
// does one node-memory read per trie level. Two items queue in front of the
// walker and one finished result waits in the output register. Nodes are
// written when allocated, so the block is usable right after reset with no
// clearing pass.
// Depends on tlpm_pkg, tlpm_front and tlpm_walker.
module trie_longest_prefix_match #(
    parameter int MAX_NODES  = tlpm_pkg::MAX_NODES_DFLT,
    parameter int PORT_COUNT = tlpm_pkg::PORT_COUNT_DFLT,
    parameter int KEY_BITS   = tlpm_pkg::KEY_BITS_DFLT,
    localparam int LEN_W     = $clog2(KEY_BITS + 1),
    localparam int PORT_W    = $clog2(PORT_COUNT)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input transactions
    input  logic                       push,
    output logic                       full,
    input  logic                       kind,
    input  logic [KEY_BITS-1:0]        prefix_value,
    input  logic [LEN_W-1:0]           prefix_length,
    input  logic [tlpm_pkg::HOP_W-1:0] route_next_hop,
    input  logic [PORT_W-1:0]          route_port,
    input  logic [KEY_BITS-1:0]        dest_address,
    // Result transactions
    output logic                       empty,
    input  logic                       pop,
    output logic                       status,
    output logic                       found,
    output logic [tlpm_pkg::HOP_W-1:0] match_next_hop,
    output logic [PORT_W-1:0]          match_port,
    output logic [LEN_W-1:0]           match_length
);

    logic                       item_valid;
    logic                       item_take;
    logic                       item_kind;
    logic [KEY_BITS-1:0]        item_key;
    logic [LEN_W-1:0]           item_len;
    logic [tlpm_pkg::HOP_W-1:0] item_hop;
    logic [PORT_W-1:0]          item_port;

    tlpm_front #(
        .KEY_BITS   (KEY_BITS),
        .PORT_COUNT (PORT_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .prefix_value   (prefix_value),
        .prefix_length  (prefix_length),
        .route_next_hop (route_next_hop),
        .route_port     (route_port),
        .dest_address   (dest_address),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .item_kind      (item_kind),
        .item_key       (item_key),
        .item_len       (item_len),
        .item_hop       (item_hop),
        .item_port      (item_port)
    );

    tlpm_walker #(
        .MAX_NODES  (MAX_NODES),
        .PORT_COUNT (PORT_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .item_kind      (item_kind),
        .item_key       (item_key),
        .item_len       (item_len),
        .item_hop       (item_hop),
        .item_port      (item_port),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .found          (found),
        .match_next_hop (match_next_hop),
        .match_port     (match_port),
        .match_length   (match_length)
    );

endmodule
